// File: src/char_lcd_write_sequencer_assert.svh
// Assertion macros used by the checker module of the LCD write sequencer.
// No dependencies; included by bare file name.
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH

// Clocked assertion, inactive while reset is held
`define CLWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset
`define CLWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/clws_pkg.sv
// Shared types, codes and the initialisation command table of the LCD write sequencer.
// No dependencies; imported by the register file, the sequencer core and the top level.
package clws_pkg;

    localparam int ADDR_W = 4;

    // request action codes
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_COMMAND = 3'd1;
    localparam logic [2:0] ACT_CHAR    = 3'd2;
    localparam logic [2:0] ACT_GOTO    = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;
    localparam logic [2:0] ACT_INIT    = 3'd5;

    // register reset values
    localparam logic       CFG_BUS_FOUR_RST = 1'b1;
    localparam logic [3:0] CFG_PULSE_RST    = 4'd1;
    localparam logic [7:0] CFG_SETTLE_RST   = 8'd5;
    localparam logic [7:0] CFG_POWERUP_RST  = 8'd100;

    // display command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] ROW0_BASE    = 8'h80;
    localparam logic [7:0] ROW1_BASE    = 8'hC0;
    localparam logic [7:0] HIGH_NIBBLE  = 8'hF0;

    localparam logic [2:0] INIT_LEN_FOUR  = 3'd7;
    localparam logic [2:0] INIT_LEN_EIGHT = 3'd5;

    typedef struct packed {
        logic       bus_four_bit;
        logic [3:0] pulse_ticks;
        logic [7:0] settle_ticks;
        logic [7:0] powerup_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [7:0] data_bus;
        logic       busy_res;
        logic       rejected;
    } t_res;

    // Initialisation command list of each bus mode; zero past the end
    function automatic logic [7:0] init_cmd(input logic four, input logic [2:0] step);
        logic [7:0] b;
        b = 8'h00;
        if (four) begin
            case (step)
                3'd0:    b = 8'h33;
                3'd1:    b = 8'h32;
                3'd2:    b = 8'h28;
                3'd3:    b = 8'h0C;
                3'd4:    b = 8'h01;
                3'd5:    b = 8'h06;
                3'd6:    b = 8'h02;
                default: b = 8'h00;
            endcase
        end else begin
            case (step)
                3'd0:    b = 8'h38;
                3'd1:    b = 8'h0C;
                3'd2:    b = 8'h01;
                3'd3:    b = 8'h06;
                3'd4:    b = 8'h02;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// File: src/clws_if.sv
// Request and result channel interfaces of the LCD write sequencer.
// Depends on nothing; used by the top level.
interface clws_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;

    modport source (output valid, action, value, row, col, input ready);
    modport sink   (input valid, action, value, row, col, output ready);
endinterface

interface clws_res_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [7:0] data_bus;
    logic       busy_res;
    logic       rejected;

    modport source (output valid, reg_select, read_write, enable, data_bus, busy_res,
                    rejected, input ready);
    modport sink   (input valid, reg_select, read_write, enable, data_bus, busy_res,
                    rejected, output ready);
endinterface

// File: src/clws_cfg.sv
// APB-style configuration register file of the LCD write sequencer.
// Depends on clws_pkg.
module clws_cfg import clws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam logic [1:0] REG_BUS_FOUR = 2'd0;
    localparam logic [1:0] REG_PULSE    = 2'd1;
    localparam logic [1:0] REG_SETTLE   = 2'd2;
    localparam logic [1:0] REG_POWERUP  = 2'd3;

    logic       w_wr;
    logic [1:0] w_idx;
    t_cfg       r_cfg;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // write the addressed register at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_four_bit  <= CFG_BUS_FOUR_RST;
            r_cfg.pulse_ticks   <= CFG_PULSE_RST;
            r_cfg.settle_ticks  <= CFG_SETTLE_RST;
            r_cfg.powerup_ticks <= CFG_POWERUP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BUS_FOUR: r_cfg.bus_four_bit  <= pwdata[0];
                REG_PULSE:    r_cfg.pulse_ticks   <= pwdata[3:0];
                REG_SETTLE:   r_cfg.settle_ticks  <= pwdata[7:0];
                REG_POWERUP:  r_cfg.powerup_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_BUS_FOUR: prdata = {31'd0, r_cfg.bus_four_bit};
            REG_PULSE:    prdata = {28'd0, r_cfg.pulse_ticks};
            REG_SETTLE:   prdata = {24'd0, r_cfg.settle_ticks};
            REG_POWERUP:  prdata = {24'd0, r_cfg.powerup_ticks};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// File: src/clws_core.sv
// Bus sequencer state and its one-request next-state logic.
// Depends on clws_pkg; driven by the top level with accepted requests.
module clws_core import clws_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_res o_res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_POWERUP = 3'd1;
    localparam logic [2:0] PH_HIGH    = 3'd2;
    localparam logic [2:0] PH_GAP     = 3'd3;
    localparam logic [2:0] PH_LOW     = 3'd4;
    localparam logic [2:0] PH_SETTLE  = 3'd5;

    logic [2:0] r_phase,       n_phase;
    logic [7:0] r_tick_count,  n_tick_count;
    logic [3:0] r_latched_lo,  n_latched_lo;
    logic [2:0] r_init_step,   n_init_step;
    logic       r_init_active, n_init_active;
    logic       r_pin_enable,  n_pin_enable;
    logic       r_pin_rs,      n_pin_rs;
    logic [7:0] r_pin_data,    n_pin_data;

    logic       w_rej;
    logic       w_settle;
    logic       w_finish;
    logic       w_start;
    logic [7:0] w_start_byte;
    logic       w_start_rs;
    logic [3:0] w_pulse;
    logic [7:0] w_tick_inc;
    logic [2:0] w_next_step;
    logic [2:0] w_list_len;

    assign w_pulse     = (i_cfg.pulse_ticks == 4'd0) ? 4'd1 : i_cfg.pulse_ticks;
    assign w_tick_inc  = r_tick_count + 8'd1;
    assign w_next_step = r_init_step + 3'd1;
    assign w_list_len  = i_cfg.bus_four_bit ? INIT_LEN_FOUR : INIT_LEN_EIGHT;

    // apply one request or tick to the sequencer state
    always_comb begin
        n_phase       = r_phase;
        n_tick_count  = r_tick_count;
        n_latched_lo  = r_latched_lo;
        n_init_step   = r_init_step;
        n_init_active = r_init_active;
        n_pin_enable  = r_pin_enable;
        n_pin_rs      = r_pin_rs;
        n_pin_data    = r_pin_data;
        w_rej         = 1'b0;
        w_settle      = 1'b0;
        w_finish      = 1'b0;
        w_start       = 1'b0;
        w_start_byte  = 8'h00;
        w_start_rs    = 1'b0;

        if (i_accept) begin
            if (i_req.action == ACT_TICK) begin
                unique case (r_phase)
                    PH_POWERUP: begin
                        n_tick_count = w_tick_inc;
                        if (w_tick_inc >= i_cfg.powerup_ticks) begin
                            w_start      = 1'b1;
                            w_start_byte = init_cmd(i_cfg.bus_four_bit, 3'd0);
                        end
                    end
                    PH_HIGH: begin
                        n_tick_count = w_tick_inc;
                        if (w_tick_inc >= {4'd0, w_pulse}) begin
                            if (i_cfg.bus_four_bit) begin
                                n_pin_enable = 1'b0;
                                n_pin_data   = {r_latched_lo, 4'd0};
                                n_tick_count = 8'd0;
                                n_phase      = PH_GAP;
                            end else begin
                                w_settle = 1'b1;
                            end
                        end
                    end
                    PH_GAP: begin
                        n_pin_enable = 1'b1;
                        n_tick_count = 8'd0;
                        n_phase      = PH_LOW;
                    end
                    PH_LOW: begin
                        n_tick_count = w_tick_inc;
                        if (w_tick_inc >= {4'd0, w_pulse}) begin
                            w_settle = 1'b1;
                        end
                    end
                    PH_SETTLE: begin
                        n_tick_count = w_tick_inc;
                        if (w_tick_inc >= i_cfg.settle_ticks) begin
                            w_finish = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else if (i_req.action <= ACT_INIT) begin
                if (r_phase != PH_IDLE) begin
                    w_rej = 1'b1;
                end else begin
                    case (i_req.action)
                        ACT_COMMAND: begin
                            w_start      = 1'b1;
                            w_start_byte = i_req.value;
                        end
                        ACT_CHAR: begin
                            w_start      = 1'b1;
                            w_start_byte = i_req.value;
                            w_start_rs   = 1'b1;
                        end
                        ACT_GOTO: begin
                            w_start      = 1'b1;
                            w_start_byte = (i_req.row ? ROW1_BASE : ROW0_BASE)
                                           + {2'd0, i_req.col};
                        end
                        ACT_CLEAR: begin
                            w_start      = 1'b1;
                            w_start_byte = CMD_CLEAR;
                        end
                        default: begin
                            n_init_active = 1'b1;
                            n_init_step   = 3'd0;
                            n_pin_enable  = 1'b0;
                            n_tick_count  = 8'd0;
                            if (i_cfg.powerup_ticks == 8'd0) begin
                                w_start      = 1'b1;
                                w_start_byte = init_cmd(i_cfg.bus_four_bit, 3'd0);
                            end else begin
                                n_phase = PH_POWERUP;
                            end
                        end
                    endcase
                end
            end
        end

        // drop enable after the last pulse and start the settle wait, if any
        if (w_settle) begin
            n_pin_enable = 1'b0;
            n_tick_count = 8'd0;
            if (i_cfg.settle_ticks == 8'd0) begin
                w_finish = 1'b1;
            end else begin
                n_phase = PH_SETTLE;
            end
        end

        // end of a byte: fetch the next init command or go idle
        if (w_finish) begin
            n_tick_count = 8'd0;
            n_phase      = PH_IDLE;
            if (r_init_active) begin
                n_init_step = w_next_step;
                if (w_next_step < w_list_len) begin
                    w_start      = 1'b1;
                    w_start_byte = init_cmd(i_cfg.bus_four_bit, w_next_step);
                end else begin
                    n_init_active = 1'b0;
                end
            end
        end

        // launch a byte: raise enable with the first data shape
        if (w_start) begin
            n_latched_lo = w_start_byte[3:0];
            n_pin_rs     = w_start_rs;
            n_pin_enable = 1'b1;
            n_pin_data   = i_cfg.bus_four_bit ? (w_start_byte & HIGH_NIBBLE) : w_start_byte;
            n_tick_count = 8'd0;
            n_phase      = PH_HIGH;
        end
    end

    // hold the sequencer state between requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tick_count  <= 8'd0;
            r_latched_lo  <= 4'd0;
            r_init_step   <= 3'd0;
            r_init_active <= 1'b0;
            r_pin_enable  <= 1'b0;
            r_pin_rs      <= 1'b0;
            r_pin_data    <= 8'd0;
        end else begin
            r_phase       <= n_phase;
            r_tick_count  <= n_tick_count;
            r_latched_lo  <= n_latched_lo;
            r_init_step   <= n_init_step;
            r_init_active <= n_init_active;
            r_pin_enable  <= n_pin_enable;
            r_pin_rs      <= n_pin_rs;
            r_pin_data    <= n_pin_data;
        end
    end

    // pin levels and status after this request
    always_comb begin
        o_res.reg_select = n_pin_rs;
        o_res.read_write = 1'b0;
        o_res.enable     = n_pin_enable;
        o_res.data_bus   = n_pin_data;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.rejected   = w_rej;
    end

endmodule

// File: src/char_lcd_write_sequencer.sv
// Latency: a result appears in the cycle after its request is accepted (one register).
// Throughput: one request or tick per cycle unless results stall; the state update for
// each request is done in its accept cycle; a result register parts the two channels.
// Reset (synchronous, active low): sequencer idle, pins low, registers at reset values,
// result register empty.
// Top level: ties the channels, the register file and the sequencer core together.
module char_lcd_write_sequencer import clws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clws_req_if.sink          i_req,
    clws_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg w_cfg;
    t_req w_req;
    t_res w_res;
    t_res r_res;
    logic r_res_valid;
    logic w_accept;

    clws_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // accept while the result register is empty or being drained
    assign i_req.ready = !r_res_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_req.action = i_req.action;
    assign w_req.value  = i_req.value;
    assign w_req.row    = i_req.row;
    assign w_req.col    = i_req.col;

    clws_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (w_req),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid      = r_res_valid;
    assign o_res.reg_select = r_res.reg_select;
    assign o_res.read_write = r_res.read_write;
    assign o_res.enable     = r_res.enable;
    assign o_res.data_bus   = r_res.data_bus;
    assign o_res.busy_res   = r_res.busy_res;
    assign o_res.rejected   = r_res.rejected;

endmodule

// File: src/clws_checker.sv
// Port-level checker for the LCD write sequencer, bound to the top level.
// Depends on char_lcd_write_sequencer_assert.svh.
`include "char_lcd_write_sequencer_assert.svh"

module clws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_reg_select,
    input logic       i_read_write,
    input logic       i_enable,
    input logic [7:0] i_data_bus,
    input logic       i_busy_res,
    input logic       i_rejected
);

    // result register empty once reset has been applied
    `CLWS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")

    // every accepted request gives a result in the next cycle
    `CLWS_ASSERT(a_accept_result, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> i_res_valid, "accepted request gave no result")

    // a stalled result holds
    `CLWS_ASSERT(a_res_hold, i_clk, i_rst_n, (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_reg_select) && $stable(i_enable) && $stable(i_data_bus) && $stable(i_busy_res) && $stable(i_rejected)), "stalled result changed")

    // a dropped request leaves the sequencer busy, and the bus is never read
    `CLWS_ASSERT(a_reject_busy, i_clk, i_rst_n, (i_res_valid && (i_rejected || i_read_write)) |-> (i_busy_res && !i_read_write), "reject while idle or read cycle")

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_reg_select (o_res.reg_select),
    .i_read_write (o_res.read_write),
    .i_enable     (o_res.enable),
    .i_data_bus   (o_res.data_bus),
    .i_busy_res   (o_res.busy_res),
    .i_rejected   (o_res.rejected)
);
